// File: rtl/obst_pkg.sv
`timescale 1ns / 1ps

package obst_pkg;

  localparam int MAX_KEYS  = 16;
  localparam int PROB_BITS = 16;

  // fixed field widths of the channels
  localparam int KIND_W   = 1;
  localparam int RANGE_W  = 5;
  localparam int COST_W   = PROB_BITS + 8;
  localparam int ROOT_W   = 5;
  localparam int STATUS_W = 2;

  // internal widths
  localparam int KEY_W    = $clog2(MAX_KEYS + 1);
  localparam int ADDR_W   = $clog2(MAX_KEYS);
  localparam int CADDR_W  = 2 * ADDR_W;
  localparam int CDEPTH   = 1 << CADDR_W;
  localparam int WEIGHT_W = PROB_BITS + $clog2(MAX_KEYS);
  localparam int CAND_W   = COST_W + 1;
  localparam int TOTAL_W  = COST_W + 2;
  localparam int QW       = ((RANGE_W > KEY_W) ? RANGE_W : KEY_W) + 1;

  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  localparam logic [KIND_W-1:0] KIND_LOAD  = 1'b0;
  localparam logic [KIND_W-1:0] KIND_QUERY = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_READY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_RANGE = 2'd2;

endpackage

// File: rtl/obst_req_if.sv
`timescale 1ns / 1ps

interface obst_req_if;
  logic                                valid;
  logic                                ready;
  logic [obst_pkg::KIND_W-1:0]         kind;
  logic [obst_pkg::PROB_BITS-1:0]      prob;
  logic                                last;
  logic [obst_pkg::RANGE_W-1:0]        range_low;
  logic [obst_pkg::RANGE_W-1:0]        range_high;

  modport source (output valid, kind, prob, last, range_low, range_high, input ready);
  modport sink   (input valid, kind, prob, last, range_low, range_high, output ready);
endinterface

// File: rtl/obst_rsp_if.sv
`timescale 1ns / 1ps

interface obst_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [obst_pkg::COST_W-1:0]         cost;
  logic [obst_pkg::ROOT_W-1:0]         root;
  logic [obst_pkg::STATUS_W-1:0]       status;

  modport source (output valid, cost, root, status, input ready);
  modport sink   (input valid, cost, root, status, output ready);
endinterface

// File: rtl/optimal_bst_cost_table.sv
`timescale 1ns / 1ps

// Optimal binary search tree cost table. Load key probabilities (unsigned
// Q0.16) one transfer each, in key order; a load with last set closes the
// set (at most 16 keys, extras dropped) and runs the dynamic program, then
// returns cost and root of the whole key set. Queries return the Q8.16 cost
// (saturating) and optimal root of keys range_low..range_high; status 1 means
// no tables yet, 2 a bad range, an empty range gives zero. One item at a time:
// a load without last only stores its weight; a query holds the block until
// its answer enters the output register; the closing load is bound by a
// single shared add-compare unit that evaluates one candidate root per cycle,
// n(n+1)(n+2)/6 candidates for n keys, with a drain after each diagonal so
// that a diagonal's writes land before the next one reads them. The cost
// table lives in a memory with two registered read ports, the root table in
// one with one registered read port; prefix weights live in a small memory.
module optimal_bst_cost_table (
  input  logic       clk,
  input  logic       rst,
  obst_req_if.sink   req,
  obst_rsp_if.source rsp
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_DRAIN,
    ST_QDATA,
    ST_PUT
  } state_t;

  state_t state;

  // control
  logic [obst_pkg::KEY_W-1:0]     key_count;
  logic                           tables_ready;
  logic [obst_pkg::WEIGHT_W-1:0]  run_sum;
  logic [obst_pkg::KEY_W-1:0]     d, i, l;
  logic                           fill_end;

  // stage B (read data back)
  logic                           s1_valid, s1_first, s1_last, s1_ea, s1_eb, s1_zb;
  logic [obst_pkg::KEY_W-1:0]     s1_l;
  logic [obst_pkg::CADDR_W-1:0]   s1_addr;
  logic [obst_pkg::COST_W-1:0]    rd_a, rd_b;
  logic [obst_pkg::KEY_W-1:0]     rd_root;
  logic [obst_pkg::WEIGHT_W-1:0]  rd_pa, rd_pb;
  logic [obst_pkg::CAND_W-1:0]    best;
  logic [obst_pkg::KEY_W-1:0]     best_root;

  // stage C (add weight, saturate, write)
  logic                           s2_valid;
  logic [obst_pkg::CAND_W-1:0]    s2_best;
  logic [obst_pkg::KEY_W-1:0]     s2_root;
  logic [obst_pkg::WEIGHT_W-1:0]  s2_weight;
  logic [obst_pkg::CADDR_W-1:0]   s2_addr;

  // pending result and output register
  logic [obst_pkg::COST_W-1:0]    res_cost;
  logic [obst_pkg::KEY_W-1:0]     res_root;
  logic [obst_pkg::STATUS_W-1:0]  res_status;
  logic                           out_valid;
  logic [obst_pkg::COST_W-1:0]    out_cost;
  logic [obst_pkg::ROOT_W-1:0]    out_root;
  logic [obst_pkg::STATUS_W-1:0]  out_status;

  // memories
  logic [obst_pkg::WEIGHT_W-1:0]  prefix_mem [obst_pkg::MAX_KEYS];
  logic [obst_pkg::COST_W-1:0]    cost_mem   [obst_pkg::CDEPTH];
  logic [obst_pkg::KEY_W-1:0]     root_mem   [obst_pkg::CDEPTH];

  // ---------------------------------------------------------------------
  // Combinational decode
  // ---------------------------------------------------------------------
  logic                           accept, load_acc, query_acc;
  logic [obst_pkg::KEY_W-1:0]     j;
  logic [obst_pkg::KEY_W-1:0]     cnt_eff, key_count_next;
  logic                           store;
  logic [obst_pkg::WEIGHT_W-1:0]  sum_eff, new_sum;
  logic [obst_pkg::QW-1:0]        q_lo, q_hi, q_n;
  logic                           q_bad, q_empty;
  logic [obst_pkg::CADDR_W-1:0]   addr_a, addr_b;
  logic [obst_pkg::ADDR_W-1:0]    paddr_a, paddr_b;
  logic [obst_pkg::CAND_W-1:0]    cand, best_new;
  logic [obst_pkg::KEY_W-1:0]     root_new;
  logic [obst_pkg::WEIGHT_W-1:0]  weight_new;
  logic [obst_pkg::TOTAL_W-1:0]   total;
  logic [obst_pkg::COST_W-1:0]    total_sat;

  assign req.ready  = (state == ST_IDLE);
  assign accept     = req.valid && req.ready;
  assign load_acc   = accept && (req.kind == obst_pkg::KIND_LOAD);
  assign query_acc  = accept && (req.kind == obst_pkg::KIND_QUERY);

  assign j = i + d;

  // a load after a finished table starts a new key set
  assign cnt_eff = tables_ready ? '0 : key_count;
  assign store   = (cnt_eff < obst_pkg::KEY_W'(obst_pkg::MAX_KEYS));
  assign key_count_next = store ? cnt_eff + 1'b1 : cnt_eff;
  assign sum_eff = (tables_ready || (key_count == '0)) ? '0 : run_sum;
  assign new_sum = sum_eff + obst_pkg::WEIGHT_W'(req.prob);

  // query range check
  assign q_lo    = obst_pkg::QW'(req.range_low);
  assign q_hi    = obst_pkg::QW'(req.range_high);
  assign q_n     = obst_pkg::QW'(key_count);
  assign q_bad   = (q_lo == '0) || (q_lo > q_n + 1'b1) || (q_hi > q_n) ||
                   (q_hi + 1'b1 < q_lo);
  assign q_empty = (q_hi + 1'b1 == q_lo);

  // read addresses: candidate root l splits i..j into i..l-1 and l+1..j
  always_comb begin
    if (state == ST_FILL) begin
      addr_a = {obst_pkg::ADDR_W'(i - 1'b1), obst_pkg::ADDR_W'(l - 2'd2)};
      addr_b = {obst_pkg::ADDR_W'(l), obst_pkg::ADDR_W'(j - 1'b1)};
    end else begin
      addr_a = {obst_pkg::ADDR_W'(q_lo - 1'b1), obst_pkg::ADDR_W'(q_hi - 1'b1)};
      addr_b = addr_a;
    end
  end
  // prefix_mem[k-1] holds the weight of keys 1..k
  assign paddr_a = obst_pkg::ADDR_W'(j - 1'b1);
  assign paddr_b = obst_pkg::ADDR_W'(i - 2'd2);

  // shared add-compare unit; strict less-than keeps the lowest root on ties
  always_comb begin
    cand = (s1_ea ? '0 : obst_pkg::CAND_W'(rd_a)) + (s1_eb ? '0 : obst_pkg::CAND_W'(rd_b));
    if (s1_first || (cand < best)) begin
      best_new = cand;
      root_new = s1_l;
    end else begin
      best_new = best;
      root_new = best_root;
    end
    weight_new = rd_pa - (s1_zb ? '0 : rd_pb);
  end

  assign total     = obst_pkg::TOTAL_W'(s2_best) + obst_pkg::TOTAL_W'(s2_weight);
  assign total_sat = (total > obst_pkg::TOTAL_W'(obst_pkg::COST_MAX)) ?
                     obst_pkg::COST_MAX : total[obst_pkg::COST_W-1:0];

  // ---------------------------------------------------------------------
  // Memories
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (load_acc && store) begin
      prefix_mem[obst_pkg::ADDR_W'(cnt_eff)] <= new_sum;
    end
    rd_pa <= prefix_mem[paddr_a];
    rd_pb <= prefix_mem[paddr_b];
  end

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      cost_mem[s2_addr] <= total_sat;
      root_mem[s2_addr] <= s2_root;
    end
    rd_a    <= cost_mem[addr_a];
    rd_b    <= cost_mem[addr_b];
    rd_root <= root_mem[addr_a];
  end

  // ---------------------------------------------------------------------
  // Sequencer, pipeline and output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      key_count    <= '0;
      tables_ready <= 1'b0;
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      fill_end     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      // ST_PUT reloads the output register itself
      if (rsp.ready && state != ST_PUT) begin
        out_valid <= 1'b0;
      end

      // stage B
      s1_valid <= (state == ST_FILL);
      s2_valid <= s1_valid && s1_last;
      if (s1_valid) begin
        best      <= best_new;
        best_root <= root_new;
        s2_best   <= best_new;
        s2_root   <= root_new;
        s2_weight <= weight_new;
        s2_addr   <= s1_addr;
      end

      // stage C: the last entry written is always 1..n, the load's answer
      if (s2_valid) begin
        res_cost <= total_sat;
        res_root <= s2_root;
      end

      case (state)
        ST_IDLE: begin
          if (load_acc) begin
            tables_ready <= 1'b0;
            key_count    <= key_count_next;
            if (store) begin
              run_sum <= new_sum;
            end
            if (req.last) begin
              d        <= '0;
              i        <= obst_pkg::KEY_W'(1);
              l        <= obst_pkg::KEY_W'(1);
              fill_end <= 1'b0;
              state    <= ST_FILL;
            end
          end else if (query_acc) begin
            res_cost <= '0;
            res_root <= '0;
            if (!tables_ready) begin
              res_status <= obst_pkg::STATUS_NOT_READY;
              state      <= ST_PUT;
            end else if (q_bad) begin
              res_status <= obst_pkg::STATUS_BAD_RANGE;
              state      <= ST_PUT;
            end else if (q_empty) begin
              res_status <= obst_pkg::STATUS_OK;
              state      <= ST_PUT;
            end else begin
              state <= ST_QDATA;
            end
          end
        end
        ST_FILL: begin
          s1_first <= (l == i);
          s1_last  <= (l == j);
          s1_ea    <= (l == i);
          s1_eb    <= (l == j);
          s1_zb    <= (i == obst_pkg::KEY_W'(1));
          s1_l     <= l;
          s1_addr  <= {obst_pkg::ADDR_W'(i - 1'b1), obst_pkg::ADDR_W'(j - 1'b1)};
          if (l == j) begin
            if (j == key_count) begin
              // diagonal done: let its writes land before the next reads
              if (d + 1'b1 == key_count) begin
                fill_end <= 1'b1;
              end else begin
                d <= d + 1'b1;
              end
              i     <= obst_pkg::KEY_W'(1);
              l     <= obst_pkg::KEY_W'(1);
              state <= ST_DRAIN;
            end else begin
              i <= i + 1'b1;
              l <= i + 1'b1;
            end
          end else begin
            l <= l + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (!s1_valid && !s2_valid) begin
            if (fill_end) begin
              tables_ready <= 1'b1;
              res_status   <= obst_pkg::STATUS_OK;
              state        <= ST_PUT;
            end else begin
              state <= ST_FILL;
            end
          end
        end
        ST_QDATA: begin
          res_cost   <= rd_a;
          res_root   <= rd_root;
          res_status <= obst_pkg::STATUS_OK;
          state      <= ST_PUT;
        end
        ST_PUT: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_cost   <= res_cost;
            out_root   <= obst_pkg::ROOT_W'(res_root);
            out_status <= res_status;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid  = out_valid;
  assign rsp.cost   = out_cost;
  assign rsp.root   = out_root;
  assign rsp.status = out_status;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_pipe_in_fill: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> (state == ST_FILL || state == ST_DRAIN))
    else $error("table write outside fill");

  a_fill_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL) |-> !tables_ready)
    else $error("tables flagged ready during fill");

  a_root_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL) |-> (l >= i && l <= j && j <= key_count))
    else $error("candidate root outside range");

  a_ready_after_drain: assert property (@(posedge clk) disable iff (rst)
    $rose(tables_ready) |-> (state == ST_PUT && !s1_valid && !s2_valid))
    else $error("tables ready before pipeline drained");

endmodule
